// ----- design/kbsc_pkg.sv -----
// Package of shared constants, types and a helper function for the k-best sample core.
package kbsc_pkg;

    localparam int DATA_W      = 64;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int K_REQ_W     = 4;
    localparam int PERIOD_W    = 8;
    localparam int MAX_KEPT    = 8;
    localparam int ADDR_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int KEPT_W      = $clog2(MAX_KEPT + 1);
    localparam int DIV_ITER_W  = $clog2(DATA_W + 1);
    localparam int QUOT_ITERS  = DATA_W;
    localparam int MOD_ITERS   = COUNT_W;

    localparam logic [K_REQ_W-1:0]    RESET_REQUIRED = 4'd5;
    localparam logic [COUNT_W-1:0]    RESET_MAX_LIMIT = 16'd300;
    localparam logic [PERIOD_W-1:0]   RESET_PERIOD = 8'd60;
    localparam logic [CFG_DATA_W-1:0] RESET_DIVISOR = 16'd100;
    localparam logic [CFG_DATA_W-1:0] RESET_BASE = 16'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQUIRED_COUNT   = 3'd0,
        CFG_MAX_SAMPLE_LIMIT = 3'd1,
        CFG_SHIFT_PERIOD     = 3'd2,
        CFG_SPREAD_DIVISOR   = 3'd3,
        CFG_BASE_ALLOWANCE   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic load_item;
        logic div_mod_start;
        logic div_quot_start;
        logic idx_clear;
        logic drop_rd;
        logic drop_wr;
        logic drop_top_wr;
        logic pos_load;
        logic ins_rd;
        logic v_load;
        logic bub_rd;
        logic bub_wr;
        logic fin_wr;
        logic rd0;
        logic rd_top;
        logic best_load;
        logic top_load;
        logic out_load;
    } kbsc_cmd_t;

    typedef struct packed {
        logic drop_cand;
        logic div_done;
        logic rem_zero;
        logic idx_last;
        logic pos_zero;
        logic bub_gt;
    } kbsc_status_t;

    function automatic logic [KEPT_W-1:0] clamp_kept(input logic [K_REQ_W-1:0] req);
        logic [KEPT_W-1:0] k;
        if (req == '0)
            k = KEPT_W'(1);
        else if (int'(req) > MAX_KEPT)
            k = KEPT_W'(MAX_KEPT);
        else
            k = KEPT_W'(req);
        return k;
    endfunction

endpackage

// ----- design/kbsc_if.sv -----
// Valid/ready channel interfaces for samples, results and register writes.
interface kbsc_sample_if;
    import kbsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] elapsed_time;
    logic              start_run;
    modport source (output valid, output elapsed_time, output start_run, input ready);
    modport sink (input valid, input elapsed_time, input start_run, output ready);
endinterface

interface kbsc_result_if;
    import kbsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  best_sample;
    logic [COUNT_W-1:0] samples_taken;
    logic               converged;
    logic               run_done;
    modport source (output valid, output best_sample, output samples_taken,
                    output converged, output run_done, input ready);
    modport sink (input valid, input best_sample, input samples_taken,
                  input converged, input run_done, output ready);
endinterface

interface kbsc_cfg_if;
    import kbsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/kbsc_div.sv -----
// Shared restoring divider, one quotient bit per cycle, with a selectable step count.
module kbsc_div
    import kbsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_W-1:0]     dividend,
    input  logic [CFG_DATA_W-1:0] divisor,
    input  logic [DIV_ITER_W-1:0] iters,
    output logic                  done,
    output logic [DATA_W-1:0]     quotient,
    output logic [CFG_DATA_W-1:0] remainder
);

    logic [DATA_W-1:0]     q_reg;
    logic [CFG_DATA_W-1:0] r_reg;
    logic [CFG_DATA_W-1:0] d_reg;
    logic [DIV_ITER_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [CFG_DATA_W:0]   trial;
    logic [CFG_DATA_W:0]   diff;
    logic                  ge;

    assign trial = {r_reg, q_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= iters;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_ITER_W'(1);
            if (cnt_reg == DIV_ITER_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DATA_W-2:0], ge};
            r_reg <= ge ? diff[CFG_DATA_W-1:0] : trial[CFG_DATA_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ----- design/kbsc_dp.sv -----
// Datapath: registers, sorted sample store, divider and result arithmetic.
module kbsc_dp
    import kbsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [DATA_W-1:0]     elapsed_time,
    input  logic                  start_run,
    input  kbsc_cmd_t             cmd,
    output kbsc_status_t          status,
    output logic [DATA_W-1:0]     best_sample,
    output logic [COUNT_W-1:0]    samples_taken,
    output logic                  converged,
    output logic                  run_done
);

    logic [K_REQ_W-1:0]    required_reg;
    logic [COUNT_W-1:0]    max_limit_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [CFG_DATA_W-1:0] divisor_reg;
    logic [CFG_DATA_W-1:0] base_reg;

    logic [COUNT_W-1:0]    cnt_reg;
    logic [COUNT_W-1:0]    s_reg;
    logic [DATA_W-1:0]     elapsed_reg;
    logic [DATA_W-1:0]     v_reg;
    logic [DATA_W-1:0]     best_reg;
    logic [DATA_W-1:0]     top_reg;
    logic [DATA_W-1:0]     delta_reg;
    logic [DATA_W-1:0]     spread_reg;
    logic [DATA_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [ADDR_W-1:0]     idx_reg;

    logic [DATA_W-1:0]     out_best_reg;
    logic [COUNT_W-1:0]    out_cnt_reg;
    logic                  out_conv_reg;
    logic                  out_done_reg;

    logic [DATA_W-1:0]     store_mem [MAX_KEPT];

    logic [KEPT_W-1:0]     k;
    logic [ADDR_W-1:0]     k_m1;
    logic [COUNT_W-1:0]    k_ext;
    logic [COUNT_W-1:0]    s_next;
    logic [COUNT_W-1:0]    cnt_next;
    logic                  s_lt_k;
    logic [ADDR_W-1:0]     pos_calc;
    logic                  place;
    logic                  conv;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [DATA_W-1:0]     mem_wd;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_ra;

    logic                  div_start;
    logic [DATA_W-1:0]     div_dividend;
    logic [CFG_DATA_W-1:0] div_divisor;
    logic [DIV_ITER_W-1:0] div_iters;
    logic                  div_done;
    logic [DATA_W-1:0]     div_quot;
    logic [CFG_DATA_W-1:0] div_rem;
    logic [DATA_W:0]       spread_sum;

    assign k        = clamp_kept(required_reg);
    assign k_m1     = ADDR_W'(k - KEPT_W'(1));
    assign k_ext    = COUNT_W'(k);
    assign s_lt_k   = s_reg < k_ext;
    assign pos_calc = s_lt_k ? s_reg[ADDR_W-1:0] : k_m1;
    assign place    = s_lt_k || (elapsed_reg < rd_data_reg);

    assign s_next   = start_run ? '0 : cnt_reg;
    assign cnt_next = (s_next == '1) ? s_next : s_next + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_reg  <= RESET_REQUIRED;
            max_limit_reg <= RESET_MAX_LIMIT;
            period_reg    <= RESET_PERIOD;
            divisor_reg   <= RESET_DIVISOR;
            base_reg      <= RESET_BASE;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_REQUIRED_COUNT:   required_reg  <= cfg_data[K_REQ_W-1:0];
                CFG_MAX_SAMPLE_LIMIT: max_limit_reg <= cfg_data[COUNT_W-1:0];
                CFG_SHIFT_PERIOD:     period_reg    <= cfg_data[PERIOD_W-1:0];
                CFG_SPREAD_DIVISOR:   divisor_reg   <= cfg_data;
                CFG_BASE_ALLOWANCE:   base_reg      <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load_item)
            cnt_reg <= cnt_next;
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg;
        mem_wd = rd_data_reg;
        if (cmd.drop_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.drop_top_wr)
        begin
            mem_we = 1'b1;
            mem_wd = '1;
        end
        else if (cmd.bub_wr)
        begin
            mem_we = 1'b1;
            mem_wa = pos_reg;
        end
        else if (cmd.fin_wr)
        begin
            mem_we = 1'b1;
            mem_wa = pos_reg;
            mem_wd = v_reg;
        end
    end

    always_comb
    begin
        mem_re = 1'b1;
        mem_ra = '0;
        if (cmd.drop_rd)
            mem_ra = idx_reg + ADDR_W'(1);
        else if (cmd.ins_rd)
            mem_ra = pos_calc;
        else if (cmd.bub_rd)
            mem_ra = pos_reg - ADDR_W'(1);
        else if (cmd.rd_top)
            mem_ra = k_m1;
        else if (!cmd.rd0)
            mem_re = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= store_mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            elapsed_reg <= elapsed_time;
            s_reg       <= s_next;
        end
        if (cmd.idx_clear)
            idx_reg <= '0;
        else if (cmd.drop_wr)
            idx_reg <= idx_reg + ADDR_W'(1);
        if (cmd.pos_load)
            pos_reg <= pos_calc;
        else if (cmd.bub_wr)
            pos_reg <= pos_reg - ADDR_W'(1);
        if (cmd.v_load)
            v_reg <= place ? elapsed_reg : rd_data_reg;
        if (cmd.best_load)
            best_reg <= rd_data_reg;
        if (cmd.top_load)
            top_reg <= rd_data_reg;
        delta_reg  <= top_reg - best_reg;
        spread_reg <= spread_sum[DATA_W] ? '1 : spread_sum[DATA_W-1:0];
    end

    assign div_start    = cmd.div_mod_start || cmd.div_quot_start;
    assign div_dividend = cmd.div_mod_start ? {s_reg, {(DATA_W-COUNT_W){1'b0}}} : best_reg;
    assign div_divisor  = cmd.div_mod_start ? CFG_DATA_W'(period_reg)
                        : ((divisor_reg == '0) ? CFG_DATA_W'(1) : divisor_reg);
    assign div_iters    = cmd.div_mod_start ? DIV_ITER_W'(MOD_ITERS) : DIV_ITER_W'(QUOT_ITERS);

    kbsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .iters     (div_iters),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign spread_sum = {1'b0, div_quot} + (DATA_W+1)'(base_reg);

    assign conv = (cnt_reg >= k_ext) && (delta_reg < spread_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_best_reg <= best_reg;
            out_cnt_reg  <= cnt_reg;
            out_conv_reg <= conv;
            out_done_reg <= conv || (cnt_reg >= max_limit_reg);
        end
    end

    assign status.drop_cand = (period_reg != '0) && !s_lt_k;
    assign status.div_done  = div_done;
    assign status.rem_zero  = (div_rem == '0);
    assign status.idx_last  = (idx_reg == k_m1);
    assign status.pos_zero  = (pos_reg == '0);
    assign status.bub_gt    = rd_data_reg > v_reg;

    assign best_sample   = out_best_reg;
    assign samples_taken = out_cnt_reg;
    assign converged     = out_conv_reg;
    assign run_done      = out_done_reg;

endmodule

// ----- design/kbsc_ctrl.sv -----
// Controller state machine that sequences one sample through the datapath.
module kbsc_ctrl
    import kbsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  kbsc_status_t status,
    output kbsc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD_START,
        S_MOD_WAIT,
        S_DROP_RD,
        S_DROP_WR,
        S_INS_RD,
        S_INS_CMP,
        S_BUB_RD,
        S_BUB_CMP,
        S_BUB_FIN,
        S_RES_RD0,
        S_RES_RD1,
        S_RES_DIV,
        S_RES_WAIT,
        S_RES_SUM,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_MOD_START;
                end
            end
            S_MOD_START:
            begin
                if (status.drop_cand)
                begin
                    cmd.div_mod_start = 1'b1;
                    state_next        = S_MOD_WAIT;
                end
                else
                    state_next = S_INS_RD;
            end
            S_MOD_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = status.rem_zero ? S_DROP_RD : S_INS_RD;
                end
            end
            S_DROP_RD:
            begin
                if (status.idx_last)
                begin
                    cmd.drop_top_wr = 1'b1;
                    state_next      = S_INS_RD;
                end
                else
                begin
                    cmd.drop_rd = 1'b1;
                    state_next  = S_DROP_WR;
                end
            end
            S_DROP_WR:
            begin
                cmd.drop_wr = 1'b1;
                state_next  = S_DROP_RD;
            end
            S_INS_RD:
            begin
                cmd.pos_load = 1'b1;
                cmd.ins_rd   = 1'b1;
                state_next   = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                cmd.v_load = 1'b1;
                state_next = S_BUB_RD;
            end
            S_BUB_RD:
            begin
                if (status.pos_zero)
                    state_next = S_BUB_FIN;
                else
                begin
                    cmd.bub_rd = 1'b1;
                    state_next = S_BUB_CMP;
                end
            end
            S_BUB_CMP:
            begin
                if (status.bub_gt)
                begin
                    cmd.bub_wr = 1'b1;
                    state_next = S_BUB_RD;
                end
                else
                    state_next = S_BUB_FIN;
            end
            S_BUB_FIN:
            begin
                cmd.fin_wr = 1'b1;
                state_next = S_RES_RD0;
            end
            S_RES_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = S_RES_RD1;
            end
            S_RES_RD1:
            begin
                cmd.best_load = 1'b1;
                cmd.rd_top    = 1'b1;
                state_next    = S_RES_DIV;
            end
            S_RES_DIV:
            begin
                cmd.top_load       = 1'b1;
                cmd.div_quot_start = 1'b1;
                state_next         = S_RES_WAIT;
            end
            S_RES_WAIT:
            begin
                if (status.div_done)
                    state_next = S_RES_SUM;
            end
            S_RES_SUM:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- design/k_best_sample_convergence_core.sv -----
// Top level of the k-best sample convergence core.
// The core takes one timing sample at a time and answers each with one result: the
// best sample, the run's sample count, and the converged and run-done flags. It works
// on one sample at a time and takes no new sample until the last one's result has been
// loaded into the output register. A sample may first go through a 16-step modulo
// pass and then a drop pass over the kept slots; it then moves down through the sample
// store, and a 64-step quotient pass of the shared bit-serial divider ends its work.
// The modulo pass uses the same divider. A finished result waits in an output register,
// and register writes are taken in any cycle.
module k_best_sample_convergence_core
    import kbsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    kbsc_sample_if.sink   sample,
    kbsc_result_if.source result,
    kbsc_cfg_if.sink      cfg
);

    kbsc_cmd_t    cmd;
    kbsc_status_t status;

    assign cfg.ready = 1'b1;

    kbsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    kbsc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .elapsed_time  (sample.elapsed_time),
        .start_run     (sample.start_run),
        .cmd           (cmd),
        .status        (status),
        .best_sample   (result.best_sample),
        .samples_taken (result.samples_taken),
        .converged     (result.converged),
        .run_done      (result.run_done)
    );

endmodule

// ----- design/kbsc_checker.sv -----
// Port-level assertions for the k-best sample core and the bind that attaches them.
module kbsc_port_checker
    import kbsc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DATA_W-1:0]  out_best,
    input logic [COUNT_W-1:0] out_count,
    input logic               out_conv,
    input logic               out_done
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_best) && $stable(out_count))
        else $error("stalled result changed");

    // Only one sample is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in work");

    // A result never appears in the cycle right after a sample transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // Convergence always ends the run, and a result always counts its own sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_conv || out_done) && (out_count != '0))
        else $error("inconsistent result flags");

endmodule

bind k_best_sample_convergence_core kbsc_port_checker u_kbsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_best  (result.best_sample),
    .out_count (result.samples_taken),
    .out_conv  (result.converged),
    .out_done  (result.run_done)
);
